[rtl/kea_pkg.sv]
// ----------------------------------------------------------------------------
// kea_pkg
// Shared types and constants of the spanning tree edge acceptor: the command
// and status words between controller and datapath.
// ----------------------------------------------------------------------------
package kea_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int VTX_W            = 13;

    // read address source of the label store
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_SWEEP
    } rd_sel_t;

    // single-entry writes into the label store
    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO,
        WR_NEW_A,
        WR_NEW_B,
        WR_LA_B,
        WR_LB_A
    } wr_op_t;

    typedef struct packed {
        logic    load_item;
        logic    clr_counters;
        logic    sweep_step;
        logic    scan_step;
        rd_sel_t rd_sel;
        logic    cap_la;
        logic    cap_lb;
        wr_op_t  wr_op;
        logic    bump_label;
        logic    count_acc;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_req;
        logic edge_valid;
        logic la_zero;
        logic lb_zero;
        logic la_eq_lb;
        logic sweep_last;
    } dp_status_t;

endpackage

[rtl/kea_datapath.sv]
// ----------------------------------------------------------------------------
// kea_datapath
// Label store, endpoint and label registers, label and edge counters, sweep
// counter for clearing and relabelling, and the result registers.
// ----------------------------------------------------------------------------
module kea_datapath #(
    parameter int MAX_VERTICES = kea_pkg::DEF_MAX_VERTICES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  kea_pkg::ctrl_cmd_t         cmd,
    output kea_pkg::dp_status_t        status,
    input  logic [kea_pkg::VTX_W-1:0]  vertex_a,
    input  logic [kea_pkg::VTX_W-1:0]  vertex_b,
    input  logic                       clear_first,
    input  logic                       last_edge,
    input  logic                       cfg_we,
    input  logic [kea_pkg::VTX_W-1:0]  cfg_wdata,
    output logic                       done,
    output logic                       accepted,
    output logic [kea_pkg::VTX_W-1:0]  end_a,
    output logic [kea_pkg::VTX_W-1:0]  end_b,
    output logic                       is_last,
    output logic                       tree_complete
);

    localparam int FW     = kea_pkg::VTX_W;
    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int LBL_W  = $clog2(MAX_VERTICES / 2 + 1);

    logic [LBL_W-1:0]  label_mem [MAX_VERTICES];

    logic [FW-1:0]     a_reg;
    logic [FW-1:0]     b_reg;
    logic              clr_reg;
    logic              last_reg;
    logic [FW-1:0]     vcount_reg;
    logic [LBL_W-1:0]  la_reg;
    logic [LBL_W-1:0]  lb_reg;
    logic [LBL_W-1:0]  rdata_reg;
    logic [LBL_W-1:0]  next_label_reg;
    logic [FW-1:0]     total_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              pend_valid_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic              acc_reg;
    logic              tree_reg;
    logic              done_reg;

    logic [FW-1:0]     eff_count;
    logic [ADDR_W-1:0] idx_a;
    logic [ADDR_W-1:0] idx_b;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [LBL_W-1:0]  wdata;
    logic              sweep_last;

    // vertex counts beyond the store act as the store size
    assign eff_count = (32'(vcount_reg) > MAX_VERTICES) ? FW'(MAX_VERTICES) : vcount_reg;

    assign idx_a = ADDR_W'(a_reg - FW'(1));
    assign idx_b = ADDR_W'(b_reg - FW'(1));

    assign sweep_last = (sweep_reg == ADDR_W'(MAX_VERTICES - 1));

    assign status.clear_req  = clr_reg;
    assign status.edge_valid = (a_reg != '0) && (b_reg != '0) && (a_reg <= eff_count)
                               && (b_reg <= eff_count) && (a_reg != b_reg);
    assign status.la_zero    = (la_reg == '0);
    assign status.lb_zero    = (lb_reg == '0);
    assign status.la_eq_lb   = (la_reg == lb_reg);
    assign status.sweep_last = sweep_last;

    always_comb
    begin
        unique case (cmd.rd_sel)
            kea_pkg::RD_A:     raddr = idx_a;
            kea_pkg::RD_B:     raddr = idx_b;
            kea_pkg::RD_SWEEP: raddr = sweep_reg;
            default:           raddr = sweep_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = sweep_reg;
        wdata = '0;
        // relabel hit from the previous scan read takes the write port
        priority if (pend_valid_reg && (rdata_reg == lb_reg))
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = la_reg;
        end
        else
        begin
            unique case (cmd.wr_op)
                kea_pkg::WR_NONE:  we = 1'b0;
                kea_pkg::WR_ZERO:
                begin
                    we    = 1'b1;
                    waddr = sweep_reg;
                    wdata = '0;
                end
                kea_pkg::WR_NEW_A:
                begin
                    we    = 1'b1;
                    waddr = idx_a;
                    wdata = next_label_reg;
                end
                kea_pkg::WR_NEW_B:
                begin
                    we    = 1'b1;
                    waddr = idx_b;
                    wdata = next_label_reg;
                end
                kea_pkg::WR_LA_B:
                begin
                    we    = 1'b1;
                    waddr = idx_b;
                    wdata = la_reg;
                end
                kea_pkg::WR_LB_A:
                begin
                    we    = 1'b1;
                    waddr = idx_a;
                    wdata = lb_reg;
                end
                default:           we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            label_mem[waddr] <= wdata;
        end
        rdata_reg <= label_mem[raddr];
    end

    // item and label payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg    <= vertex_a;
            b_reg    <= vertex_b;
            last_reg <= last_edge;
        end
        if (cmd.cap_la)
        begin
            la_reg <= rdata_reg;
        end
        if (cmd.cap_lb)
        begin
            lb_reg <= rdata_reg;
        end
        pend_addr_reg <= sweep_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg        <= 1'b0;
            vcount_reg     <= FW'(1);
            next_label_reg <= '0;
            total_reg      <= '0;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            acc_reg        <= 1'b0;
            tree_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (cmd.load_item)
            begin
                clr_reg <= clear_first;
                acc_reg <= 1'b0;
            end
            if (cmd.clr_counters)
            begin
                clr_reg        <= 1'b0;
                next_label_reg <= '0;
                total_reg      <= '0;
            end
            else
            begin
                if (cmd.bump_label && (next_label_reg != '1))
                begin
                    next_label_reg <= next_label_reg + LBL_W'(1);
                end
                if (cmd.count_acc && (total_reg != '1))
                begin
                    total_reg <= total_reg + FW'(1);
                end
            end
            if (cmd.count_acc)
            begin
                acc_reg <= 1'b1;
            end
            if (cmd.sweep_step || cmd.scan_step)
            begin
                sweep_reg <= sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            pend_valid_reg <= cmd.scan_step;
            done_reg       <= cmd.emit;
            if (cmd.emit)
            begin
                tree_reg <= last_reg && (eff_count != '0)
                            && (({1'b0, total_reg} + (FW + 1)'(1)) == {1'b0, eff_count});
            end
        end
    end

    assign done          = done_reg;
    assign accepted      = acc_reg;
    assign end_a         = a_reg;
    assign end_b         = b_reg;
    assign is_last       = last_reg;
    assign tree_complete = tree_reg;

endmodule

[rtl/kea_ctrl.sv]
// ----------------------------------------------------------------------------
// kea_ctrl
// Sequencer of the edge acceptor: clearing pass, label lookup, label update
// or full relabel sweep, and result strobe.
// ----------------------------------------------------------------------------
module kea_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  kea_pkg::dp_status_t  status,
    output kea_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_ENTRY,
        S_CLR,
        S_CHECK,
        S_RD_B,
        S_WAIT_B,
        S_DECIDE,
        S_NEW_A,
        S_NEW_B,
        S_SCAN,
        S_SCAN_TAIL,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.rd_sel       = kea_pkg::RD_SWEEP;
        cmd.wr_op        = kea_pkg::WR_NONE;
        unique case (state_reg)
            S_INIT_CLR:
            begin
                cmd.wr_op        = kea_pkg::WR_ZERO;
                cmd.sweep_step   = 1'b1;
                cmd.clr_counters = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ENTRY;
                end
            end
            S_ENTRY:
            begin
                state_next = status.clear_req ? S_CLR : S_CHECK;
            end
            S_CLR:
            begin
                cmd.wr_op        = kea_pkg::WR_ZERO;
                cmd.sweep_step   = 1'b1;
                cmd.clr_counters = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.rd_sel = kea_pkg::RD_A;
                state_next = status.edge_valid ? S_RD_B : S_RESULT;
            end
            S_RD_B:
            begin
                cmd.rd_sel = kea_pkg::RD_B;
                cmd.cap_la = 1'b1;
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                cmd.cap_lb = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                priority if (status.la_zero && status.lb_zero)
                begin
                    cmd.bump_label = 1'b1;
                    cmd.count_acc  = 1'b1;
                    state_next     = S_NEW_A;
                end
                else if (status.lb_zero)
                begin
                    cmd.wr_op     = kea_pkg::WR_LA_B;
                    cmd.count_acc = 1'b1;
                    state_next    = S_RESULT;
                end
                else if (status.la_zero)
                begin
                    cmd.wr_op     = kea_pkg::WR_LB_A;
                    cmd.count_acc = 1'b1;
                    state_next    = S_RESULT;
                end
                else if (!status.la_eq_lb)
                begin
                    cmd.count_acc = 1'b1;
                    state_next    = S_SCAN;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_NEW_A:
            begin
                cmd.wr_op  = kea_pkg::WR_NEW_A;
                state_next = S_NEW_B;
            end
            S_NEW_B:
            begin
                cmd.wr_op  = kea_pkg::WR_NEW_B;
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_SCAN_TAIL;
                end
            end
            // last relabel write lands here
            S_SCAN_TAIL:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/kruskal_edge_acceptor.sv]
// Per edge: S_ENTRY and S_CHECK, then S_RESULT directly for an edge with an invalid endpoint;
// else label reads and S_DECIDE, then a label copy, a new label, a merge or a same-label reject.
// clear_first adds a clearing pass over the whole store; one edge at a time, busy high meanwhile.
// After reset busy stays high while the label store is zeroed.
// done pulses for one cycle with the result word; the receiver cannot stall.
// ----------------------------------------------------------------------------
// kruskal_edge_acceptor
// Kruskal spanning tree edge acceptor: component labels per vertex, accept
// flag per edge and tree completion on the last edge.
// ----------------------------------------------------------------------------
module kruskal_edge_acceptor #(
    parameter int MAX_VERTICES = kea_pkg::DEF_MAX_VERTICES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [kea_pkg::VTX_W-1:0]  vertex_a,
    input  logic [kea_pkg::VTX_W-1:0]  vertex_b,
    input  logic                       clear_first,
    input  logic                       last_edge,
    input  logic                       cfg_we,
    input  logic [kea_pkg::VTX_W-1:0]  cfg_wdata,
    output logic                       done,
    output logic                       accepted,
    output logic [kea_pkg::VTX_W-1:0]  end_a,
    output logic [kea_pkg::VTX_W-1:0]  end_b,
    output logic                       is_last,
    output logic                       tree_complete
);

    kea_pkg::ctrl_cmd_t  cmd;
    kea_pkg::dp_status_t status;

    kea_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    kea_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .vertex_a      (vertex_a),
        .vertex_b      (vertex_b),
        .clear_first   (clear_first),
        .last_edge     (last_edge),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .accepted      (accepted),
        .end_a         (end_a),
        .end_b         (end_b),
        .is_last       (is_last),
        .tree_complete (tree_complete)
    );

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted edge did not raise busy");

    a_no_self_loop: assert property (@(posedge clk) disable iff (!rst_n)
        done && accepted |-> end_a != end_b)
        else $error("self-loop accepted");

    a_tree_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && tree_complete |-> is_last)
        else $error("tree_complete on a word that is not last");
`endif

endmodule

[sim/tb_kruskal_edge_acceptor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kruskal_edge_acceptor
// Drives edge words into the spanning tree edge acceptor and checks the
// accept flag, the echoed ends and the tree completion bit of every result
// against a component label model kept in the bench, across several vertex
// counts.
// ----------------------------------------------------------------------------
module tb_kruskal_edge_acceptor;

    localparam int MAX_V = 4096;
    localparam int VW    = kea_pkg::VTX_W;

    typedef struct {
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic          clr;
        logic          last;
        int unsigned   gap;
    } edge_word_t;

    typedef struct packed {
        logic          acc;
        logic [VW-1:0] a;
        logic [VW-1:0] b;
        logic          last;
        logic          tree;
    } edge_result_t;

    logic          clk;
    logic          rst_n         = 1'b0;
    logic          start         = 1'b0;
    logic [VW-1:0] vertex_a      = '0;
    logic [VW-1:0] vertex_b      = '0;
    logic          clear_first   = 1'b0;
    logic          last_edge     = 1'b0;
    logic          cfg_we        = 1'b0;
    logic [VW-1:0] cfg_wdata     = '0;
    logic          busy;
    logic          done;
    logic          accepted;
    logic [VW-1:0] end_a;
    logic [VW-1:0] end_b;
    logic          is_last;
    logic          tree_complete;

    edge_word_t   edge_queue[$];
    edge_result_t pending_results[$];
    bit           word_taken = 1'b0;
    bit           no_idle    = 1'b0;
    int           mismatch_count = 0;

    // label model state
    int comp_label[MAX_V];
    int label_hwm  = 0;
    int tree_edges = 0;
    int graph_size = 1;

    kruskal_edge_acceptor #(
        .MAX_VERTICES(MAX_V)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .clear_first  (clear_first),
        .last_edge    (last_edge),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .done         (done),
        .accepted     (accepted),
        .end_a        (end_a),
        .end_b        (end_b),
        .is_last      (is_last),
        .tree_complete(tree_complete)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #120_000_000;
        $display("tb_kruskal_edge_acceptor: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // one edge through the label model
    function automatic edge_result_t resolve_edge(input logic [VW-1:0] a,
                                                  input logic [VW-1:0] b,
                                                  input logic clr,
                                                  input logic last);
        edge_result_t r;
        int n;
        int va;
        int vb;
        int la;
        int lb;
        bit joins;
        n  = (graph_size > MAX_V) ? MAX_V : graph_size;
        va = int'(a);
        vb = int'(b);
        joins = 1'b0;
        if (clr)
        begin
            foreach (comp_label[j])
                comp_label[j] = 0;
            label_hwm  = 0;
            tree_edges = 0;
        end
        if (va >= 1 && vb >= 1 && va <= n && vb <= n && va != vb)
        begin
            la = comp_label[va-1];
            lb = comp_label[vb-1];
            if (la == 0 && lb == 0)
            begin
                label_hwm++;
                comp_label[va-1] = label_hwm;
                comp_label[vb-1] = label_hwm;
                joins = 1'b1;
            end
            else if (lb == 0)
            begin
                comp_label[vb-1] = la;
                joins = 1'b1;
            end
            else if (la == 0)
            begin
                comp_label[va-1] = lb;
                joins = 1'b1;
            end
            else if (la != lb)
            begin
                // merge sweeps the whole store, stale entries included
                foreach (comp_label[j])
                    if (comp_label[j] == lb)
                        comp_label[j] = la;
                joins = 1'b1;
            end
            if (joins && tree_edges < 8191)
                tree_edges++;
        end
        r.acc  = joins;
        r.a    = a;
        r.b    = b;
        r.last = last;
        r.tree = last && n >= 1 && tree_edges == n - 1;
        return r;
    endfunction

    // driver: words change on the falling edge
    always @(negedge clk)
    begin : driver
        static int idle_cycles = 0;
        edge_word_t w;
        if (rst_n && (!start || word_taken))
        begin
            if (edge_queue.size() != 0 && idle_cycles < edge_queue[0].gap)
            begin
                idle_cycles++;
                start <= 1'b0;
            end
            else if (edge_queue.size() != 0)
            begin
                w = edge_queue.pop_front();
                vertex_a    <= w.a;
                vertex_b    <= w.b;
                clear_first <= w.clr;
                last_edge   <= w.last;
                start       <= 1'b1;
                idle_cycles = 0;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results checked and words predicted on the rising edge
    always @(posedge clk)
    begin : monitor
        edge_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 32'(end_a), 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (accepted !== want.acc)
                        report_mismatch("accepted", 32'(accepted), 32'(want.acc));
                    if (end_a !== want.a)
                        report_mismatch("end_a", 32'(end_a), 32'(want.a));
                    if (end_b !== want.b)
                        report_mismatch("end_b", 32'(end_b), 32'(want.b));
                    if (is_last !== want.last)
                        report_mismatch("is_last", 32'(is_last), 32'(want.last));
                    if (tree_complete !== want.tree)
                        report_mismatch("tree_complete", 32'(tree_complete),
                                        32'(want.tree));
                end
            end
            if (cfg_we)
                graph_size = int'(cfg_wdata);
            if (start && !busy)
            begin
                pending_results.push_back(resolve_edge(vertex_a, vertex_b,
                                                       clear_first, last_edge));
                word_taken <= 1'b1;
            end
            else
            begin
                word_taken <= 1'b0;
            end
        end
    end

    task automatic add_edge(input int a, input int b, input bit clr, input bit last);
        edge_word_t w;
        w.a    = VW'(a);
        w.b    = VW'(b);
        w.clr  = clr;
        w.last = last;
        w.gap  = no_idle ? 0 : $urandom_range(0, 13);
        edge_queue.push_back(w);
    endtask

    // sender holds until every word is through and every result is back
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (edge_queue.size() != 0 || start || pending_results.size() != 0 || busy);
    endtask

    task automatic set_vertex_count(input int count);
        wait_quiet();
        cfg_wdata <= VW'(count);
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int pick_vertex(input int eff);
        int x;
        if (eff == 0)
            return $urandom_range(0, 8191);
        x = $urandom_range(1, (eff < 12) ? eff : 12);
        if (eff > 12 && $urandom_range(0, 3) == 0)
            x = eff + 1 - x;
        if (eff > 12 && $urandom_range(0, 7) == 0)
            x = $urandom_range(1, eff);
        return x;
    endfunction

    initial
    begin : stimulus
        int cfg_now;
        int eff;
        int pick;
        int n_edges;
        int random_items;
        int a;
        int b;
        bit clr;
        bit last;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: every kind of label update and rejection
        set_vertex_count(4096);
        add_edge(1, 2, 1, 0);
        add_edge(2, 3, 0, 0);
        add_edge(5, 3, 0, 0);
        add_edge(4096, 4095, 0, 0);
        add_edge(1, 4096, 0, 0);
        add_edge(3, 4095, 0, 0);
        add_edge(7, 7, 0, 0);
        add_edge(0, 5, 0, 0);
        add_edge(4097, 1, 0, 0);
        add_edge(8191, 0, 0, 0);
        add_edge(6, 4094, 0, 1);
        // smaller count without a clear, so high entries go stale
        set_vertex_count(6);
        add_edge(4, 6, 0, 0);
        add_edge(6, 2, 0, 0);
        add_edge(7, 1, 0, 1);
        set_vertex_count(8191);
        add_edge(4096, 6, 0, 0);
        add_edge(4094, 4093, 0, 1);
        set_vertex_count(0);
        add_edge(1, 2, 1, 1);
        add_edge(0, 0, 0, 1);
        set_vertex_count(1);
        add_edge(1, 1, 1, 1);
        add_edge(1, 2, 0, 1);
        set_vertex_count(3);
        add_edge(1, 2, 1, 0);
        add_edge(3, 2, 0, 0);
        add_edge(1, 3, 0, 0);
        add_edge(2, 3, 0, 1);
        cfg_now = 3;

        // random graphs, mostly well formed with some noise
        random_items = 0;
        while (random_items < 116)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    cfg_now = 0;
                else if (pick == 1)
                    cfg_now = 1;
                else if (pick == 2)
                    cfg_now = 4096;
                else if (pick == 3)
                    cfg_now = $urandom_range(4097, 8191);
                else if (pick < 6)
                    cfg_now = $urandom_range(13, 4096);
                else
                    cfg_now = $urandom_range(2, 10);
                set_vertex_count(cfg_now);
            end
            eff = (cfg_now > MAX_V) ? MAX_V : cfg_now;
            no_idle = ($urandom_range(0, 2) == 0);
            if (eff >= 2 && eff <= 10)
                n_edges = $urandom_range(eff - 1, eff + 5);
            else
                n_edges = $urandom_range(1, 10);
            for (int e = 0; e < n_edges; e++)
            begin
                clr  = (e == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 30) == 0);
                last = (e == n_edges - 1) ? 1'b1 : ($urandom_range(0, 25) == 0);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    a = $urandom_range(0, 8191);
                    b = $urandom_range(0, 8191);
                end
                else if (pick == 1)
                begin
                    // one end out of range
                    a = pick_vertex(eff);
                    case ($urandom_range(0, 2))
                        0: b = 0;
                        1: b = eff + 1;
                        default: b = 8191;
                    endcase
                    if ($urandom_range(0, 1))
                    begin
                        pick = a;
                        a = b;
                        b = pick;
                    end
                end
                else
                begin
                    a = pick_vertex(eff);
                    b = pick_vertex(eff);
                end
                add_edge(a, b, clr, last);
                random_items++;
            end
        end

        wait_quiet();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_kruskal_edge_acceptor: PASS");
        else
            $display("tb_kruskal_edge_acceptor: FAIL");
        $finish;
    end

endmodule
